### rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and controller/datapath interface types for the
// text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Screen geometry.
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELLS      = COLUMNS * ROWS;
    localparam int KEEP_CELLS = COLUMNS * (ROWS - 1);

    // Field widths.
    localparam int KIND_W   = 2;
    localparam int CHAR_W   = 8;
    localparam int INDEX_W  = 11;
    localparam int DATA_W   = 16;
    localparam int CURSOR_W = 11;
    localparam int ATTR_W   = 8;

    // Internal widths.
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int CNT_W  = $clog2(CELLS + 2);

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0f;

    // Control characters.
    localparam logic [CHAR_W-1:0] CODE_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CODE_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_RETURN    = 8'd13;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCROLL,
        ST_EXEC,
        ST_READ,
        ST_READ_WAIT,
        ST_CLEAR,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic cnt_clear;
        logic scroll_step;
        logic clear_step;
        logic exec_char;
        logic read_issue;
        logic read_capture;
        logic cursor_scrolled;
        logic cursor_zero;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic at_end;
        logic scroll_last;
        logic clear_last;
    } status_t;

endpackage

### rtl/core/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Controller state machine: input handshake, sequencing of sweeps and
// character steps, and the output valid flag.
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [tcw_pkg::KIND_W-1:0]  kind,
    input  logic                        out_stall,
    input  tcw_pkg::status_t            status,
    output logic                        in_stall,
    output logic                        out_valid,
    output tcw_pkg::cmd_t               cmd
);
    import tcw_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    cmd.cnt_clear = 1'b1;
                    unique case (kind)
                        KIND_PUT:   state_next = status.at_end ? ST_SCROLL : ST_EXEC;
                        KIND_READ:  state_next = ST_READ;
                        KIND_CLEAR: state_next = ST_CLEAR;
                        default:    state_next = ST_FINISH;
                    endcase
                end
            end
            ST_SCROLL:
            begin
                cmd.scroll_step = 1'b1;
                if (status.scroll_last)
                begin
                    cmd.cursor_scrolled = 1'b1;
                    state_next          = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec_char = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_READ:
            begin
                cmd.read_issue = 1'b1;
                state_next     = ST_READ_WAIT;
            end
            ST_READ_WAIT:
            begin
                cmd.read_capture = 1'b1;
                state_next       = ST_FINISH;
            end
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    cmd.cursor_zero = 1'b1;
                    state_next      = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

### rtl/core/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath
// Screen memory, cursor and column tracking, sweep counter, attribute
// register and the output register.
// ----------------------------------------------------------------------------
module tcw_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tcw_pkg::cmd_t                 cmd,
    output tcw_pkg::status_t              status,
    input  logic                          cfg_write_en,
    input  logic [tcw_pkg::ATTR_W-1:0]    cfg_write_data,
    input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
    input  logic [tcw_pkg::INDEX_W-1:0]   cell_index,
    output logic [tcw_pkg::DATA_W-1:0]    read_data,
    output logic [tcw_pkg::CURSOR_W-1:0]  cursor
);
    import tcw_pkg::*;

    logic [ATTR_W-1:0]   attr_reg;
    logic [CURSOR_W-1:0] cursor_reg;
    logic [CURSOR_W-1:0] cursor_next;
    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    col_next;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;
    logic [CHAR_W-1:0]   char_reg;
    logic [INDEX_W-1:0]  index_reg;
    logic [DATA_W-1:0]   res_data_reg;
    logic [DATA_W-1:0]   res_data_next;
    logic [DATA_W-1:0]   out_data_reg;
    logic [CURSOR_W-1:0] out_cursor_reg;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              index_in_range;
    logic [CURSOR_W-1:0] col_ext;

    tcw_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign index_in_range = index_reg < INDEX_W'(CELLS);
    assign col_ext        = CURSOR_W'(col_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg   <= ATTR_RESET;
            cursor_reg <= '0;
            col_reg    <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                attr_reg <= cfg_write_data;
            end
            cursor_reg <= cursor_next;
            col_reg    <= col_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            char_reg  <= char_code;
            index_reg <= cell_index;
        end
        res_data_reg <= res_data_next;
        if (cmd.out_load)
        begin
            out_data_reg   <= res_data_reg;
            out_cursor_reg <= cursor_reg;
        end
    end

    // Sweep counter, shared by scroll and clear.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.cnt_clear)
        begin
            cnt_next = '0;
        end
        else if (cmd.scroll_step || cmd.clear_step)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    // Memory ports, cursor and column.
    always_comb
    begin
        wr_en       = 1'b0;
        wr_addr     = '0;
        wr_data     = '0;
        rd_en       = 1'b0;
        rd_addr     = '0;
        cursor_next = cursor_reg;
        col_next    = col_reg;

        if (cmd.clear_step)
        begin
            wr_en   = 1'b1;
            wr_addr = cnt_reg[ADDR_W-1:0];
        end
        else if (cmd.scroll_step)
        begin
            // Read one row ahead; the registered data lands one cell behind.
            rd_en   = cnt_reg < CNT_W'(KEEP_CELLS);
            rd_addr = ADDR_W'(cnt_reg + CNT_W'(COLUMNS));
            wr_en   = cnt_reg != '0;
            wr_addr = ADDR_W'(cnt_reg - CNT_W'(1));
            wr_data = (cnt_reg <= CNT_W'(KEEP_CELLS)) ? rd_data : '0;
        end
        else if (cmd.exec_char)
        begin
            unique case (char_reg)
                CODE_NEWLINE:
                begin
                    cursor_next = cursor_reg - col_ext + CURSOR_W'(COLUMNS);
                    col_next    = '0;
                end
                CODE_RETURN:
                begin
                    cursor_next = cursor_reg - col_ext;
                    col_next    = '0;
                end
                CODE_BACKSPACE:
                begin
                    if (cursor_reg != '0)
                    begin
                        cursor_next = cursor_reg - CURSOR_W'(1);
                        col_next    = (col_reg == '0) ? COL_W'(COLUMNS - 1)
                                                      : col_reg - COL_W'(1);
                        wr_en       = 1'b1;
                        wr_addr     = ADDR_W'(cursor_reg - CURSOR_W'(1));
                    end
                end
                default:
                begin
                    wr_en       = 1'b1;
                    wr_addr     = ADDR_W'(cursor_reg);
                    wr_data     = {attr_reg, char_reg};
                    cursor_next = cursor_reg + CURSOR_W'(1);
                    col_next    = (col_reg == COL_W'(COLUMNS - 1)) ? '0
                                                                    : col_reg + COL_W'(1);
                end
            endcase
        end
        else if (cmd.read_issue)
        begin
            rd_en   = index_in_range;
            rd_addr = ADDR_W'(index_reg);
        end

        if (cmd.cursor_scrolled)
        begin
            cursor_next = CURSOR_W'(KEEP_CELLS);
            col_next    = '0;
        end
        else if (cmd.cursor_zero)
        begin
            cursor_next = '0;
            col_next    = '0;
        end
    end

    always_comb
    begin
        res_data_next = res_data_reg;
        if (cmd.load_item)
        begin
            res_data_next = '0;
        end
        else if (cmd.read_capture)
        begin
            res_data_next = index_in_range ? rd_data : '0;
        end
    end

    assign status.at_end      = cursor_reg == CURSOR_W'(CELLS);
    assign status.scroll_last = cnt_reg == CNT_W'(CELLS);
    assign status.clear_last  = cnt_reg == CNT_W'(CELLS - 1);

    assign read_data = out_data_reg;
    assign cursor    = out_cursor_reg;

endmodule

### rtl/core/text_console_writer_top.sv
// ----------------------------------------------------------------------------
// text_console_writer_top
// Character-cell text console: an 80 x 25 screen of attribute/character
// cells with a cursor, written one item at a time.
// ----------------------------------------------------------------------------
// Use: an item (kind, char_code, cell_index) is one beat on the input
// channel, taken at a clock edge with in_valid high and in_stall low. Each
// item yields exactly one result beat (read_data, cursor) on the output
// channel, taken when out_valid is high and out_stall is low.
// cfg_write_en/cfg_write_data load the attribute byte used for new cells.
// On the way to the output register a put runs a character step, a read
// issues the memory read and then captures the data, and a clear sweeps
// zeros through every cell. A put issued with the cursor one past the last
// cell first scrolls the screen up one row, once per screen row. The rate
// is set by the single write port of the screen memory, which the scroll
// sweeps cell by cell; a new item is taken only once the block is idle.
// After reset the block sweeps zeros through every cell of the screen
// memory with in_stall held high; configuration writes are taken.
// A stalled result sits in the output register while the block goes back to
// idle and takes the next beat; that item then waits for the register.
// ----------------------------------------------------------------------------
module text_console_writer_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [tcw_pkg::KIND_W-1:0]    kind,
    input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
    input  logic [tcw_pkg::INDEX_W-1:0]   cell_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [tcw_pkg::DATA_W-1:0]    read_data,
    output logic [tcw_pkg::CURSOR_W-1:0]  cursor,
    input  logic                          cfg_write_en,
    input  logic [tcw_pkg::ATTR_W-1:0]    cfg_write_data
);
    import tcw_pkg::*;

    cmd_t    cmd;
    status_t status;

    // The controller owns the handshakes and sequencing; it sees the item
    // kind directly so it can dispatch in the accepting cycle.
    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .kind      (kind),
        .out_stall (out_stall),
        .status    (status),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // The datapath holds the screen memory, the cursor with its column,
    // the sweep counter and the result register.
    tcw_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .char_code      (char_code),
        .cell_index     (cell_index),
        .read_data      (read_data),
        .cursor         (cursor)
    );

    // A character step never runs with the cursor past the screen: the
    // scroll must have happened first.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec_char |-> !status.at_end)
        else $error("character step issued with cursor past the last cell");

    // The reported cursor never goes beyond one past the last cell.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (cursor <= CURSOR_W'(CELLS)))
        else $error("cursor out of range on result beat");

    // A new result appears only after the block was busy with an item.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result beat appeared without a busy cycle");

endmodule

### verif/text_console_writer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_checker
// Watches the item, result and attribute ports of the text console, keeps its
// own copy of the screen and cursor, and compares every result beat against
// the predicted cell contents and cursor.
// ----------------------------------------------------------------------------
module text_console_writer_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [tcw_pkg::KIND_W-1:0]   kind,
    input  logic [tcw_pkg::CHAR_W-1:0]   char_code,
    input  logic [tcw_pkg::INDEX_W-1:0]  cell_index,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [tcw_pkg::DATA_W-1:0]   read_data,
    input  logic [tcw_pkg::CURSOR_W-1:0] cursor,
    input  logic                         cfg_write_en,
    input  logic [tcw_pkg::ATTR_W-1:0]   cfg_write_data,
    output int                           fail_count,
    output int                           pending_count
);
    import tcw_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0]   data;
        logic [CURSOR_W-1:0] cursor;
    } console_result_t;

    logic [DATA_W-1:0] screen [CELLS];
    int                cursor_at;
    logic [ATTR_W-1:0] attribute;
    console_result_t   due_results [$];
    int                errs = 0;

    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++)
            screen[i] = '0;
        cursor_at = 0;
    endfunction

    function automatic void put_char(logic [CHAR_W-1:0] ch);
        // A put with the cursor one past the last cell scrolls up one row first.
        if (cursor_at >= CELLS) begin
            for (int i = 0; i < KEEP_CELLS; i++)
                screen[i] = screen[i + COLUMNS];
            for (int i = KEEP_CELLS; i < CELLS; i++)
                screen[i] = '0;
            cursor_at = KEEP_CELLS;
        end
        if (ch == CODE_NEWLINE)
            cursor_at += COLUMNS - (cursor_at % COLUMNS);
        else if (ch == CODE_BACKSPACE) begin
            if (cursor_at > 0) begin
                cursor_at--;
                screen[cursor_at] = '0;
            end
        end
        else if (ch == CODE_RETURN)
            cursor_at -= cursor_at % COLUMNS;
        else begin
            screen[cursor_at] = {attribute, ch};
            cursor_at++;
        end
    endfunction

    function automatic console_result_t console_apply(logic [KIND_W-1:0]  k,
                                                      logic [CHAR_W-1:0]  ch,
                                                      logic [INDEX_W-1:0] idx);
        console_result_t r;
        r.data = '0;
        case (k)
            KIND_PUT:   put_char(ch);
            KIND_READ:  if (idx < CELLS) r.data = screen[idx];
            KIND_CLEAR: blank_screen();
            default:    ;
        endcase
        r.cursor = cursor_at[CURSOR_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        console_result_t want;
        if (!rst_n)
        begin
            blank_screen();
            attribute = ATTR_RESET;
            due_results.delete();
            pending_count <= 0;
        end
        else
        begin
            // Results are retired before new items are predicted; a result can
            // never belong to an item taken at the same edge.
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    errs++;
                    $error("result beat with no item pending: read_data %h, cursor %0d",
                           read_data, cursor);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (read_data !== want.data)
                    begin
                        errs++;
                        $error("read_data: expected %h, actual %h", want.data, read_data);
                    end
                    if (cursor !== want.cursor)
                    begin
                        errs++;
                        $error("cursor: expected %0d, actual %0d", want.cursor, cursor);
                    end
                end
            end
            if (in_valid && !in_stall)
                due_results.push_back(console_apply(kind, char_code, cell_index));
            if (cfg_write_en)
                attribute = cfg_write_data;
            pending_count <= due_results.size();
        end
        fail_count <= errs;
    end

endmodule

### verif/text_console_writer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer_top_test
// Drives the text console with a directed set of items and then phases of
// random text, reads and clears under changing attributes, with random gaps
// and output stalls; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module text_console_writer_top_test;
    import tcw_pkg::*;

    // Kind 3 has no function; the block must leave the screen and cursor alone.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [KIND_W-1:0]   kind;
    logic [CHAR_W-1:0]   char_code;
    logic [INDEX_W-1:0]  cell_index;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [DATA_W-1:0]   read_data;
    logic [CURSOR_W-1:0] cursor;
    logic                cfg_write_en;
    logic [ATTR_W-1:0]   cfg_write_data;

    int fail_count;
    int pending_count;

    // Percent of cycles in which the sender holds back a beat, and a flag that
    // switches off the receiver's stalls for one phase.
    int   gap_pct = 36;
    logic calm = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    text_console_writer_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .char_code      (char_code),
        .cell_index     (cell_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .read_data      (read_data),
        .cursor         (cursor),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    text_console_writer_checker checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .char_code      (char_code),
        .cell_index     (cell_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .read_data      (read_data),
        .cursor         (cursor),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .fail_count     (fail_count),
        .pending_count  (pending_count)
    );

    // The receiver stalls about a third of the time, except in the calm phase.
    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(0, 99) < 36);

    // Offers one beat, possibly after a random gap, and returns at the edge
    // where it was taken. Valid is left high so that a following beat with no
    // gap goes out back to back with a single assignment in that time step.
    task automatic send_beat(logic [KIND_W-1:0] k, logic [CHAR_W-1:0] ch,
                             logic [INDEX_W-1:0] idx);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= k;
        char_code  <= ch;
        cell_index <= idx;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drops valid and waits until every predicted result has come back, which
    // leaves the block idle and safe for an attribute write.
    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_count != 0);
    endtask

    task automatic write_attribute(logic [ATTR_W-1:0] value);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    // One random beat. Most beats are puts, so the cursor walks down the screen
    // and reaches the bottom, where scrolls happen; nl_pct sets how often a put
    // is a newline, which decides between short lines and lines that wrap.
    // Reads favor the top and bottom rows where text tends to sit, and a small
    // share of beats are the unused kind or a clear.
    task automatic random_beat(int nl_pct);
        int                 r;
        int                 s;
        logic [KIND_W-1:0]  k;
        logic [CHAR_W-1:0]  ch;
        logic [INDEX_W-1:0] idx;
        r   = $urandom_range(0, 199);
        ch  = CHAR_W'($urandom_range(0, 255));
        idx = INDEX_W'($urandom_range(0, 2047));
        k   = KIND_PUT;
        if (r < 140)
        begin
            s = $urandom_range(0, 99);
            if (s < nl_pct)
                ch = CODE_NEWLINE;
            else if (s < nl_pct + 6)
                ch = CODE_BACKSPACE;
            else if (s < nl_pct + 9)
                ch = CODE_RETURN;
        end
        else if (r < 182)
        begin
            k = KIND_READ;
            case ($urandom_range(0, 2))
                0:       idx = INDEX_W'($urandom_range(0, 2 * COLUMNS - 1));
                1:       idx = INDEX_W'($urandom_range(KEEP_CELLS - COLUMNS, CELLS - 1));
                default: ;
            endcase
        end
        else if (r < 198)
            k = KIND_UNUSED;
        else
            k = KIND_CLEAR;
        send_beat(k, ch, idx);
    endtask

    initial
    begin
        int nl_pct;
        in_valid       = 1'b0;
        kind           = KIND_PUT;
        char_code      = '0;
        cell_index     = '0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        rst_n          = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, under the reset attribute. The first beat waits out
        // the clearing sweep that follows reset, since in_stall is held high.
        send_beat(KIND_READ, 8'h00, 11'd0);            // cleared screen reads zero
        send_beat(KIND_PUT, CODE_BACKSPACE, 11'd0);    // backspace at cell zero
        send_beat(KIND_PUT, CODE_RETURN, 11'd0);       // return on the first row
        send_beat(KIND_PUT, 8'h41, 11'd0);
        send_beat(KIND_PUT, 8'h00, 11'd0);             // lowest character byte
        send_beat(KIND_PUT, 8'hff, 11'h7ff);           // highest character byte
        send_beat(KIND_READ, 8'h00, 11'd0);
        send_beat(KIND_READ, 8'h00, 11'd2);
        send_beat(KIND_PUT, CODE_BACKSPACE, 11'd0);    // blanks the last cell written
        send_beat(KIND_READ, 8'h00, 11'd2);
        send_beat(KIND_PUT, CODE_RETURN, 11'd0);
        send_beat(KIND_PUT, CODE_NEWLINE, 11'd0);
        send_beat(KIND_UNUSED, 8'hff, 11'h7ff);        // unused kind changes nothing
        send_beat(KIND_PUT, 8'h5a, 11'd0);
        send_beat(KIND_READ, 8'h00, 11'd80);
        send_beat(KIND_READ, 8'h00, 11'd1);
        send_beat(KIND_READ, 8'hff, 11'd1999);         // last cell
        send_beat(KIND_READ, 8'h00, 11'd2000);         // first index off the screen
        send_beat(KIND_READ, 8'h00, 11'h7ff);          // highest index
        send_beat(KIND_CLEAR, 8'hff, 11'h7ff);
        send_beat(KIND_READ, 8'h00, 11'd80);
        wait_drained();

        // Random phases. The attribute changes only between phases, with the
        // block drained; the first two phases use its extremes. Phase four
        // runs with no gaps and no stalls at all.
        for (int p = 0; p < 10; p++)
        begin
            nl_pct  = (p % 3 == 0) ? 35 : (p % 3 == 1) ? 15 : 3;
            gap_pct = (p == 4) ? 0 : 36;
            calm   <= (p == 4);
            case (p)
                0:       write_attribute(8'h00);
                1:       write_attribute(8'hff);
                default: write_attribute(ATTR_W'($urandom_range(0, 255)));
            endcase
            if (p == 5 || p == 9)
                send_beat(KIND_CLEAR, CHAR_W'($urandom_range(0, 255)),
                          INDEX_W'($urandom_range(0, 2047)));
            repeat (64) random_beat(nl_pct);
            wait_drained();
        end

        // Nothing is outstanding; give a stray late beat time to show up.
        repeat (40) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Allows for every beat costing a scroll plus a put, with stalls and gaps,
    // several times over.
    initial
    begin
        #12_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_ram.sv
rtl/core/tcw_ctrl.sv
rtl/core/tcw_datapath.sv
rtl/core/text_console_writer_top.sv
verif/text_console_writer_checker.sv
verif/text_console_writer_top_test.sv
